// ----- rtl/olsu_pkg.sv -----
// olsu_pkg: shared constants, codes and cell control types of the ordered list store
// no dependencies; imported by olsu_cell and ordered_list_store_unit
package olsu_pkg;

    localparam int DEF_CAPACITY = 16;
    localparam int DATA_W       = 32;
    localparam int COUNT_W      = 5;

    // request actions
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_SEARCH = 2'd2;
    localparam logic [1:0] ACT_DUMP   = 2'd3;

    // result status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;
    localparam logic [1:0] STAT_EMPTY     = 2'd3;

    // command that every cell carries out on its stored value
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_ROTATE = 2'd3
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t           cmd;
        logic [DATA_W-1:0]   key;
        logic [DATA_W-1:0]   head;
    } cell_ctrl_t;

endpackage

// ----- rtl/olsu_cell.sv -----
// olsu_cell: one list position, holds a value, compares it with the key and
// shifts to or from its neighbors; depends on olsu_pkg
module olsu_cell
    import olsu_pkg::*;
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic [DATA_W-1:0] left_value,
    input  logic [DATA_W-1:0] right_value,
    input  logic              right_valid,
    input  logic              valid,
    input  logic              before_in,
    output logic [DATA_W-1:0] value,
    output logic              before_out,
    output logic              hit
);

    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;
    logic              match;

    assign match      = valid && (value_reg == ctrl.key);
    assign hit        = match && !before_in;
    assign before_out = before_in || match;
    assign value      = value_reg;

    always_comb
    begin
        unique case (ctrl.cmd)
            CELL_HOLD:   value_next = value_reg;
            CELL_INSERT: value_next = left_value;
            // cells from the first match backward pull from the right
            CELL_DELETE: value_next = before_out ? right_value : value_reg;
            // the last valid cell takes the head so the list comes back whole
            CELL_ROTATE: value_next = right_valid ? right_value : ctrl.head;
            default:     value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// ----- rtl/ordered_list_store_unit.sv -----
// ordered_list_store_unit: top level of the ordered list store, a row of olsu_cell
// positions with count, dump sequencer and result register; depends on olsu_pkg, olsu_cell
//
// Bounded list of signed 32-bit values kept newest first, one cell per position.
// Insert, delete and search each take one request and give one result; every cell
// compares the key in parallel and the whole row shifts in the same cycle, so these
// requests are accepted one per cycle as long as results are taken. A dump gives
// one result per entry, front to back, by rotating the row one position a cycle while
// results are taken; the request sets the dump state, from which each entry goes into
// the result register, and new requests are held off until the last entry. After reset the
// list is empty; no clearing pass is needed.
module ordered_list_store_unit
    import olsu_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // request channel
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               action,
    input  logic signed [DATA_W-1:0] key_value,
    // result channel
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               status,
    output logic signed [DATA_W-1:0] item_value,
    output logic                     has_left,
    output logic signed [DATA_W-1:0] left_value,
    output logic                     has_right,
    output logic signed [DATA_W-1:0] right_value,
    output logic [COUNT_W-1:0]       entry_count,
    output logic                     last
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DUMP = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     occ_reg, occ_next;
    logic [CW-1:0]     idx_reg, idx_next;

    // result register
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        status_reg, status_next;
    logic [DATA_W-1:0] item_reg, item_next;
    logic              has_left_reg, has_left_next;
    logic [DATA_W-1:0] left_reg, left_next;
    logic              has_right_reg, has_right_next;
    logic [DATA_W-1:0] right_reg, right_next;
    logic              last_reg, last_next;
    logic              load_out;

    // cell row
    cell_ctrl_t        ctrl;
    logic [DATA_W-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0] cell_valid;
    logic [CAPACITY-1:0] cell_hit;
    logic [CAPACITY:0]   before_chain;

    logic              in_accept;
    logic              out_free;
    logic              found;
    logic              full;
    logic              dump_last;
    logic              nb_has_left, nb_has_right;
    logic [DATA_W-1:0] nb_left, nb_right;

    assign before_chain[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            localparam logic [CW-1:0] IDX = CW'(g);
            logic [DATA_W-1:0] lv;
            logic [DATA_W-1:0] rv;
            logic              rvalid;

            // a position is live while it lies below the count
            assign cell_valid[g] = (IDX < occ_reg);

            if (g == 0)
            begin : g_front
                assign lv = ctrl.key;
            end
            else
            begin : g_mid_l
                assign lv = cell_value[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_back
                assign rv     = '0;
                assign rvalid = 1'b0;
            end
            else
            begin : g_mid_r
                assign rv     = cell_value[g+1];
                assign rvalid = cell_valid[g+1];
            end

            olsu_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .left_value  (lv),
                .right_value (rv),
                .right_valid (rvalid),
                .valid       (cell_valid[g]),
                .before_in   (before_chain[g]),
                .value       (cell_value[g]),
                .before_out  (before_chain[g+1]),
                .hit         (cell_hit[g])
            );
        end
    endgenerate

    // neighbors of the single hit cell
    always_comb
    begin
        nb_has_left  = 1'b0;
        nb_has_right = 1'b0;
        nb_left      = '0;
        nb_right     = '0;
        for (int i = 1; i < CAPACITY; i++)
        begin
            if (cell_hit[i])
            begin
                nb_has_left = 1'b1;
                nb_left     = nb_left | cell_value[i-1];
            end
        end
        for (int i = 0; i < CAPACITY - 1; i++)
        begin
            if (cell_hit[i] && cell_valid[i+1])
            begin
                nb_has_right = 1'b1;
                nb_right     = nb_right | cell_value[i+1];
            end
        end
    end

    assign found     = |cell_hit;
    assign full      = (occ_reg == CAP_C);
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign in_accept = in_valid && !in_stall;
    assign dump_last = (CW'(idx_reg + CW'(1)) == occ_reg);

    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        idx_next       = idx_reg;
        ctrl.cmd       = CELL_HOLD;
        ctrl.key       = key_value;
        ctrl.head      = cell_value[0];
        load_out       = 1'b0;
        status_next    = status_reg;
        item_next      = item_reg;
        has_left_next  = 1'b0;
        left_next      = '0;
        has_right_next = 1'b0;
        right_next     = '0;
        last_next      = 1'b1;

        if (in_accept)
        begin
            unique case (action)
                ACT_INSERT:
                begin
                    load_out  = 1'b1;
                    item_next = key_value;
                    if (full)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        status_next = STAT_OK;
                        ctrl.cmd    = CELL_INSERT;
                        occ_next    = occ_reg + CW'(1);
                    end
                end
                ACT_DELETE:
                begin
                    load_out  = 1'b1;
                    item_next = key_value;
                    if (found)
                    begin
                        status_next = STAT_OK;
                        ctrl.cmd    = CELL_DELETE;
                        occ_next    = occ_reg - CW'(1);
                    end
                    else
                    begin
                        status_next = STAT_NOT_FOUND;
                    end
                end
                ACT_SEARCH:
                begin
                    load_out = 1'b1;
                    if (found)
                    begin
                        status_next    = STAT_OK;
                        item_next      = key_value;
                        has_left_next  = nb_has_left;
                        left_next      = nb_left;
                        has_right_next = nb_has_right;
                        right_next     = nb_right;
                    end
                    else
                    begin
                        status_next = STAT_NOT_FOUND;
                        item_next   = '0;
                    end
                end
                ACT_DUMP:
                begin
                    if (occ_reg == '0)
                    begin
                        load_out    = 1'b1;
                        status_next = STAT_EMPTY;
                        item_next   = '0;
                    end
                    else
                    begin
                        state_next = ST_DUMP;
                        idx_next   = '0;
                    end
                end
                default:
                begin
                    load_out = 1'b0;
                end
            endcase
        end
        else if ((state_reg == ST_DUMP) && out_free)
        begin
            // emit the head and rotate the row one place toward the front
            load_out    = 1'b1;
            ctrl.cmd    = CELL_ROTATE;
            status_next = STAT_OK;
            item_next   = cell_value[0];
            last_next   = dump_last;
            idx_next    = idx_reg + CW'(1);
            if (dump_last)
            begin
                state_next = ST_IDLE;
            end
        end
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded only with a new result
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            status_reg    <= status_next;
            item_reg      <= item_next;
            has_left_reg  <= has_left_next;
            left_reg      <= left_next;
            has_right_reg <= has_right_next;
            right_reg     <= right_next;
            last_reg      <= last_next;
        end
    end

    // count after the step is the live count once the result is shown
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign item_value  = item_reg;
    assign has_left    = has_left_reg;
    assign left_value  = left_reg;
    assign has_right   = has_right_reg;
    assign right_value = right_reg;
    assign entry_count = COUNT_W'(occ_reg);
    assign last        = last_reg;

    // count never passes the capacity
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CAP_C)
        else $error("entry count above capacity");

    // at most one cell reports the first match
    a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cell_hit))
        else $error("more than one first match");

    // dump position stays inside the live part of the row
    a_dump_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DUMP) |-> (idx_reg < occ_reg))
        else $error("dump index past count");

    // no request is taken while a dump runs
    a_dump_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DUMP) |-> in_stall)
        else $error("request accepted during dump");

    // an accepted insert into a list with room grows it by one
    a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (action == ACT_INSERT) && !full)
        |=> (occ_reg == CW'($past(occ_reg) + CW'(1))))
        else $error("insert did not grow the list");

endmodule

// ----- verif/tb_ordered_list_store_unit.sv -----
// tb_ordered_list_store_unit: self-checking testbench for the ordered list store, with a
// directed table, shaped random request sequences and a shadow list that predicts every result
// depends on olsu_pkg and ordered_list_store_unit
module tb_ordered_list_store_unit;
    import olsu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY      = DEF_CAPACITY;
    localparam int RANDOM_ITEMS  = 76;
    localparam int CALM_ITEMS    = 20;   // last random requests run with no idling
    localparam int STALL_LIMIT   = 200;  // cycles with no handshake before giving up
    localparam int TAIL_CYCLES   = 20;

    localparam logic signed [DATA_W-1:0] MAX_V = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] MIN_V = 32'sh8000_0000;

    // one result as it leaves the block
    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] item_value;
        logic                     has_left;
        logic signed [DATA_W-1:0] left_value;
        logic                     has_right;
        logic signed [DATA_W-1:0] right_value;
        logic [COUNT_W-1:0]       entry_count;
        logic                     last;
    } list_result_t;

    // one directed request; pinned rows carry their result typed in by hand
    typedef struct packed {
        logic [1:0]               act;
        logic signed [DATA_W-1:0] key;
        logic                     pinned;
        list_result_t             want;
    } directed_row_t;

    localparam list_result_t NO_WANT = '0;

    localparam int DIR_ROWS = 24;
    localparam directed_row_t DIRECTED [DIR_ROWS] = '{
        // empty list after reset
        '{ACT_DUMP,   32'sd0, 1'b1,
          '{STAT_EMPTY, 32'sd0, 1'b0, 32'sd0, 1'b0, 32'sd0, 5'd0, 1'b1}},
        '{ACT_SEARCH, 32'sd5, 1'b1,
          '{STAT_NOT_FOUND, 32'sd0, 1'b0, 32'sd0, 1'b0, 32'sd0, 5'd0, 1'b1}},
        '{ACT_DELETE, 32'sd5, 1'b1,
          '{STAT_NOT_FOUND, 32'sd5, 1'b0, 32'sd0, 1'b0, 32'sd0, 5'd0, 1'b1}},
        // lone entry: no neighbours either side
        '{ACT_INSERT, MAX_V,  1'b1,
          '{STAT_OK, MAX_V, 1'b0, 32'sd0, 1'b0, 32'sd0, 5'd1, 1'b1}},
        '{ACT_SEARCH, MAX_V,  1'b1,
          '{STAT_OK, MAX_V, 1'b0, 32'sd0, 1'b0, 32'sd0, 5'd1, 1'b1}},
        '{ACT_DUMP,   -32'sd1, 1'b1,
          '{STAT_OK, MAX_V, 1'b0, 32'sd0, 1'b0, 32'sd0, 5'd1, 1'b1}},
        '{ACT_INSERT, MIN_V,  1'b1,
          '{STAT_OK, MIN_V, 1'b0, 32'sd0, 1'b0, 32'sd0, 5'd2, 1'b1}},
        '{ACT_INSERT, 32'sd0,  1'b0, NO_WANT},
        '{ACT_INSERT, -32'sd1, 1'b0, NO_WANT},
        // middle, front and back hits
        '{ACT_SEARCH, 32'sd0,  1'b0, NO_WANT},
        '{ACT_SEARCH, -32'sd1, 1'b0, NO_WANT},
        '{ACT_SEARCH, MAX_V,   1'b0, NO_WANT},
        '{ACT_SEARCH, 32'sd7,  1'b1,
          '{STAT_NOT_FOUND, 32'sd0, 1'b0, 32'sd0, 1'b0, 32'sd0, 5'd4, 1'b1}},
        // duplicate value: first match from the front wins
        '{ACT_INSERT, 32'sd0,  1'b0, NO_WANT},
        '{ACT_SEARCH, 32'sd0,  1'b0, NO_WANT},
        '{ACT_DELETE, 32'sd0,  1'b0, NO_WANT},
        '{ACT_DUMP,   32'sd0,  1'b0, NO_WANT},
        // delete at back, then at front
        '{ACT_DELETE, MAX_V,   1'b0, NO_WANT},
        '{ACT_DELETE, -32'sd1, 1'b0, NO_WANT},
        '{ACT_DELETE, 32'sh5A5A_5A5A, 1'b1,
          '{STAT_NOT_FOUND, 32'sh5A5A_5A5A, 1'b0, 32'sd0, 1'b0, 32'sd0, 5'd2, 1'b1}},
        '{ACT_DUMP,   MAX_V,   1'b0, NO_WANT},
        '{ACT_DELETE, MIN_V,   1'b0, NO_WANT},
        '{ACT_DELETE, 32'sd0,  1'b0, NO_WANT},
        // back to empty, key ignored
        '{ACT_DUMP,   -32'sd1, 1'b1,
          '{STAT_EMPTY, 32'sd0, 1'b0, 32'sd0, 1'b0, 32'sd0, 5'd0, 1'b1}}
    };

    logic                     clk;
    logic                     rst_n      = 1'b0;
    logic                     in_valid   = 1'b0;
    logic                     in_stall;
    logic [1:0]               action     = ACT_INSERT;
    logic signed [DATA_W-1:0] key_value  = '0;
    logic                     out_valid;
    logic                     out_stall  = 1'b0;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] item_value;
    logic                     has_left;
    logic signed [DATA_W-1:0] left_value;
    logic                     has_right;
    logic signed [DATA_W-1:0] right_value;
    logic [COUNT_W-1:0]       entry_count;
    logic                     last;

    // shadow copy of the list, front at index 0
    logic signed [DATA_W-1:0] shadow_entries [CAPACITY];
    int                       shadow_count = 0;

    list_result_t pending_results [$];
    int           mismatch_count = 0;
    int           random_sent    = 0;
    bit           idle_on        = 1'b1;
    int           stall_burst    = 0;
    int           quiet_cycles   = 0;

    ordered_list_store_unit #(
        .CAPACITY (CAPACITY)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .key_value   (key_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .item_value  (item_value),
        .has_left    (has_left),
        .left_value  (left_value),
        .has_right   (has_right),
        .right_value (right_value),
        .entry_count (entry_count),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // apply one accepted request to the shadow list and queue the results it causes
    function automatic void predict_list_results(input logic [1:0] act,
                                                 input logic signed [DATA_W-1:0] key);
        list_result_t r;
        int           pos;
        pos = -1;
        r   = '0;
        r.last = 1'b1;
        // first match from the front, used by delete and search
        for (int i = 0; i < shadow_count; i++)
        begin
            if (pos < 0 && shadow_entries[i] == key)
                pos = i;
        end
        case (act)
            ACT_INSERT:
            begin
                r.item_value = key;
                if (shadow_count >= CAPACITY)
                    r.status = STAT_FULL;
                else
                begin
                    for (int i = shadow_count; i > 0; i--)
                        shadow_entries[i] = shadow_entries[i-1];
                    shadow_entries[0] = key;
                    shadow_count++;
                    r.status = STAT_OK;
                end
                r.entry_count = COUNT_W'(shadow_count);
                pending_results.push_back(r);
            end
            ACT_DELETE:
            begin
                r.item_value = key;
                if (pos < 0)
                    r.status = STAT_NOT_FOUND;
                else
                begin
                    // close the gap behind the removed entry
                    for (int i = pos; i + 1 < shadow_count; i++)
                        shadow_entries[i] = shadow_entries[i+1];
                    shadow_count--;
                    r.status = STAT_OK;
                end
                r.entry_count = COUNT_W'(shadow_count);
                pending_results.push_back(r);
            end
            ACT_SEARCH:
            begin
                if (pos < 0)
                    r.status = STAT_NOT_FOUND;
                else
                begin
                    r.status     = STAT_OK;
                    r.item_value = shadow_entries[pos];
                    if (pos > 0)
                    begin
                        r.has_left   = 1'b1;
                        r.left_value = shadow_entries[pos-1];
                    end
                    if (pos + 1 < shadow_count)
                    begin
                        r.has_right   = 1'b1;
                        r.right_value = shadow_entries[pos+1];
                    end
                end
                r.entry_count = COUNT_W'(shadow_count);
                pending_results.push_back(r);
            end
            default:
            begin
                r.entry_count = COUNT_W'(shadow_count);
                if (shadow_count == 0)
                begin
                    r.status = STAT_EMPTY;
                    pending_results.push_back(r);
                end
                else
                begin
                    // one result per entry, front to back
                    for (int i = 0; i < shadow_count; i++)
                    begin
                        r.status     = STAT_OK;
                        r.item_value = shadow_entries[i];
                        r.last       = (i == shadow_count - 1);
                        pending_results.push_back(r);
                    end
                end
            end
        endcase
    endfunction

    function automatic void report_field(input string field,
                                         input logic signed [63:0] want_v,
                                         input logic signed [63:0] got_v);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
        mismatch_count++;
    endfunction

    function automatic void compare_result(input list_result_t want, input list_result_t got);
        if (got.status !== want.status)
            report_field("status", want.status, got.status);
        if (got.item_value !== want.item_value)
            report_field("item_value", want.item_value, got.item_value);
        if (got.has_left !== want.has_left)
            report_field("has_left", want.has_left, got.has_left);
        if (got.left_value !== want.left_value)
            report_field("left_value", want.left_value, got.left_value);
        if (got.has_right !== want.has_right)
            report_field("has_right", want.has_right, got.has_right);
        if (got.right_value !== want.right_value)
            report_field("right_value", want.right_value, got.right_value);
        if (got.entry_count !== want.entry_count)
            report_field("entry_count", want.entry_count, got.entry_count);
        if (got.last !== want.last)
            report_field("last", want.last, got.last);
    endfunction

    // drive one request and hold it until the block takes it; called at a rising edge
    task automatic send_request(input logic [1:0] act, input logic signed [DATA_W-1:0] key,
                                input logic pinned, input list_result_t want);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            // idle burst with junk on the payload
            gap = $urandom_range(1, 3);
            in_valid  <= 1'b0;
            action    <= 2'($urandom);
            key_value <= $urandom;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        action    <= act;
        key_value <= key;
        do
            @(posedge clk);
        while (in_stall);
        predict_list_results(act, key);
        // a pinned row replaces the predicted single result with the typed one
        if (pinned)
        begin
            void'(pending_results.pop_back());
            pending_results.push_back(want);
        end
    endtask

    task automatic send_random(input logic [1:0] act, input logic signed [DATA_W-1:0] key);
        send_request(act, key, 1'b0, NO_WANT);
        random_sent++;
        if (random_sent >= RANDOM_ITEMS - CALM_ITEMS)
            idle_on = 1'b0;
    endtask

    // sender holds off until every queued result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // mostly keys already in the list, so delete and search hit
    function automatic logic signed [DATA_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6 && shadow_count > 0)
            return shadow_entries[$urandom_range(0, shadow_count - 1)];
        else if (r < 8)
            return DATA_W'($signed($urandom_range(0, 6)) - 3);
        else
            return $urandom;
    endfunction

    // result side: check accepted results, then pick the next stall value
    always @(posedge clk)
    begin : result_check
        list_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{status, item_value, has_left, left_value,
                    has_right, right_value, entry_count, last};
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with no request pending, actual status %0d item %0d",
                         $time, got.status, got.item_value);
                mismatch_count++;
            end
            else
                compare_result(pending_results.pop_front(), got);
        end
        // random stall bursts, started only while idling is on
        if (stall_burst > 0)
        begin
            stall_burst--;
            out_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            stall_burst = $urandom_range(0, 2);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // watchdog: too long with no handshake on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int kind;
        int n;
        logic [1:0] act;
        int r;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < DIR_ROWS; i++)
            send_request(DIRECTED[i].act, DIRECTED[i].key, DIRECTED[i].pinned,
                         DIRECTED[i].want);
        wait_drained();

        // shaped random sequences; the first one always fills the list
        kind = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            case (kind)
                0:
                begin
                    // fill to capacity, then a refused insert or two and a dump
                    while (shadow_count < CAPACITY)
                        send_random(ACT_INSERT, ($urandom_range(0, 1) != 0) ?
                                    DATA_W'($urandom) : pick_key());
                    n = $urandom_range(1, 2);
                    repeat (n) send_random(ACT_INSERT, $urandom);
                    send_random(ACT_DUMP, $urandom);
                end
                1:
                begin
                    // drain with the odd miss mixed in
                    while (shadow_count > 0 && random_sent < RANDOM_ITEMS)
                    begin
                        if ($urandom_range(0, 4) == 0)
                            send_random(ACT_DELETE, $urandom);
                        else
                            send_random(ACT_DELETE,
                                        shadow_entries[$urandom_range(0, shadow_count - 1)]);
                    end
                    send_random(ACT_DUMP, $urandom);
                end
                default:
                begin
                    n = $urandom_range(4, 10);
                    repeat (n)
                    begin
                        r = $urandom_range(0, 9);
                        if (r < 4)
                            act = ACT_INSERT;
                        else if (r < 6)
                            act = ACT_DELETE;
                        else if (r < 9)
                            act = ACT_SEARCH;
                        else
                            act = ACT_DUMP;
                        send_random(act, pick_key());
                    end
                end
            endcase
            if ($urandom_range(0, 5) == 0)
                wait_drained();
            r = $urandom_range(0, 9);
            kind = (r == 0) ? 0 : (r < 3) ? 1 : 2;
        end

        // let everything come back, then a short quiet tail
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/olsu_pkg.sv
rtl/olsu_cell.sv
rtl/ordered_list_store_unit.sv
verif/tb_ordered_list_store_unit.sv
